FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is held.
`define HBE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("%m: check failed");

// Check a property on every rising edge, reset cycles included.
`define HBE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

FILE: rtl/hbe_pkg.sv
package hbe_pkg;

    localparam int MAX_ORDER_DEF = 6;
    localparam int KEY_BYTES     = 36;
    localparam int KEY_IDX_W     = 6;
    localparam int VALUE_W       = 19;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 24;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_4 = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_PUSH
    } hbe_state_t;

    typedef struct packed {
        logic store;
        logic mac;
        logic push;
    } hbe_cmd_t;

    typedef struct packed {
        logic block_done;
        logic term_last;
        logic col_last;
        logic out_free;
    } hbe_sts_t;

endpackage

FILE: rtl/hbe_ctrl.sv
module hbe_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  hbe_pkg::hbe_sts_t sts,
    output hbe_pkg::hbe_cmd_t cmd
);

    hbe_pkg::hbe_state_t state_reg;
    hbe_pkg::hbe_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hbe_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hbe_pkg::ST_IDLE: begin
                if (s_tvalid && sts.block_done) begin
                    state_next = hbe_pkg::ST_MAC;
                end
            end
            hbe_pkg::ST_MAC: begin
                if (sts.term_last) begin
                    state_next = hbe_pkg::ST_PUSH;
                end
            end
            hbe_pkg::ST_PUSH: begin
                if (sts.out_free) begin
                    state_next = sts.col_last ? hbe_pkg::ST_IDLE : hbe_pkg::ST_MAC;
                end
            end
            default: state_next = hbe_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        cmd.store = 1'b0;
        cmd.mac   = 1'b0;
        cmd.push  = 1'b0;
        case (state_reg)
            hbe_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.store = s_tvalid;
            end
            hbe_pkg::ST_MAC: begin
                cmd.mac = 1'b1;
            end
            hbe_pkg::ST_PUSH: begin
                cmd.push = sts.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/hbe_dp.sv
module hbe_dp #(
    parameter int MAX_ORDER = hbe_pkg::MAX_ORDER_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [hbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hbe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic [7:0]                      s_byte,
    input  logic                            s_last,
    input  hbe_pkg::hbe_cmd_t               cmd,
    output hbe_pkg::hbe_sts_t               sts,
    input  logic                            m_ready,
    output logic                            m_valid,
    output logic [hbe_pkg::VALUE_W-1:0]     m_value,
    output logic                            m_last
);

    localparam int ORD_W = $clog2(MAX_ORDER + 1);
    localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam logic [ORD_W-1:0] MAX_N = ORD_W'(MAX_ORDER);
    localparam int KW = hbe_pkg::KEY_IDX_W;
    localparam int VW = hbe_pkg::VALUE_W;

    logic [2:0]  block_size_reg;
    logic [63:0] key_word_0_reg;
    logic [63:0] key_word_1_reg;
    logic [63:0] key_word_2_reg;
    logic [63:0] key_word_3_reg;
    logic [31:0] key_word_4_reg;

    logic [7:0]       blk_buf [MAX_ORDER];
    logic [ORD_W-1:0] fill_reg;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    logic [KW-1:0]    k_reg;
    logic [VW-1:0]    acc_reg;
    logic             m_valid_reg;
    logic [VW-1:0]    m_value_reg;
    logic             m_last_reg;

    logic [ORD_W-1:0] n_eff;
    logic [IDX_W-1:0] pos;
    logic [ORD_W-1:0] fill_next;
    logic [63:0]      kword;
    logic [7:0]       key_b;
    logic [7:0]       msg_b;
    logic [15:0]      prod;
    logic [VW-1:0]    acc_next;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg <= 3'd1;
            key_word_0_reg <= '0;
            key_word_1_reg <= '0;
            key_word_2_reg <= '0;
            key_word_3_reg <= '0;
            key_word_4_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                hbe_pkg::REG_BLOCK_SIZE: block_size_reg <= cfg_wdata[2:0];
                hbe_pkg::REG_KEY_WORD_0: key_word_0_reg <= cfg_wdata;
                hbe_pkg::REG_KEY_WORD_1: key_word_1_reg <= cfg_wdata;
                hbe_pkg::REG_KEY_WORD_2: key_word_2_reg <= cfg_wdata;
                hbe_pkg::REG_KEY_WORD_3: key_word_3_reg <= cfg_wdata;
                hbe_pkg::REG_KEY_WORD_4: key_word_4_reg <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // effective matrix order, clamped to 1..MAX_ORDER
    always_comb begin
        if (block_size_reg == 3'd0) begin
            n_eff = ORD_W'(1);
        end else if (int'(block_size_reg) > MAX_ORDER) begin
            n_eff = MAX_N;
        end else begin
            n_eff = ORD_W'(block_size_reg);
        end
    end

    // drop a stale partial block if the order was lowered under it
    always_comb begin
        if (fill_reg >= n_eff) begin
            pos = '0;
        end else begin
            pos = fill_reg[IDX_W-1:0];
        end
        fill_next = ORD_W'(pos) + ORD_W'(1);
    end

    always_comb begin
        case (k_reg[KW-1:3])
            3'd0:    kword = key_word_0_reg;
            3'd1:    kword = key_word_1_reg;
            3'd2:    kword = key_word_2_reg;
            3'd3:    kword = key_word_3_reg;
            3'd4:    kword = {32'd0, key_word_4_reg};
            default: kword = '0;
        endcase
        if (int'(k_reg) >= hbe_pkg::KEY_BYTES) begin
            key_b = 8'd0;
        end else begin
            key_b = 8'(kword >> {k_reg[2:0], 3'b000});
        end
        msg_b    = (ORD_W'(i_reg) < fill_reg) ? blk_buf[i_reg] : 8'd0;
        prod     = 16'(msg_b) * 16'(key_b);
        acc_next = acc_reg + VW'(prod);
    end

    assign sts.block_done = (fill_next >= n_eff) || s_last;
    assign sts.term_last  = (ORD_W'(i_reg) == n_eff - ORD_W'(1));
    assign sts.col_last   = (ORD_W'(j_reg) == n_eff - ORD_W'(1));
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            blk_buf[pos] <= s_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            i_reg    <= '0;
            j_reg    <= '0;
            k_reg    <= '0;
            acc_reg  <= '0;
        end else if (cmd.store) begin
            fill_reg <= fill_next;
            i_reg    <= '0;
            j_reg    <= '0;
            k_reg    <= '0;
            acc_reg  <= '0;
        end else if (cmd.mac) begin
            acc_reg <= acc_next;
            i_reg   <= i_reg + IDX_W'(1);
            k_reg   <= k_reg + KW'(n_eff);
        end else if (cmd.push) begin
            if (sts.col_last) begin
                fill_reg <= '0;
            end else begin
                j_reg   <= j_reg + IDX_W'(1);
                i_reg   <= '0;
                k_reg   <= KW'(j_reg) + KW'(1);
                acc_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_value_reg <= acc_reg;
            m_last_reg  <= sts.col_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_last  = m_last_reg;

endmodule

FILE: rtl/hill_block_encrypt.sv
// Channel   Dir  tdata                         tlast           tuser
// s_        in   [7:0] message_byte            end_of_message  -
// m_        out  [18:0] cipher_value, 0 pad    block_last      -
// cfg_      in   write port: cfg_index selects the register, cfg_wdata its value
//
// A byte that does not close its block is stored and the input stays ready.
// A closing byte starts the compute for an order-n key: one shared
// 8x8 multiply-accumulate runs n steps per column, then each column sum loads
// the output register once it is free; the input is held off meanwhile.
// The output register parts the sides: a new byte is taken while a result waits.
// aresetn is synchronous; no clearing pass follows it.
module hill_block_encrypt #(
    parameter int MAX_ORDER = hbe_pkg::MAX_ORDER_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [hbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hbe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // plaintext stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hbe_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] message_byte
    input  logic                            s_tlast,
    // cipher stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hbe_pkg::M_TDATA_W-1:0]   m_tdata,   // [18:0] cipher_value
    output logic                            m_tlast
);

    hbe_pkg::hbe_cmd_t cmd;
    hbe_pkg::hbe_sts_t sts;
    logic [hbe_pkg::VALUE_W-1:0] m_value;

    // sequence each block: accept bytes, then step the MAC column by column
    hbe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // hold key, block buffer, counters, accumulator and output beat
    hbe_dp #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_byte    (s_tdata[7:0]),
        .s_last    (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .m_ready   (m_tready),
        .m_valid   (m_tvalid),
        .m_value   (m_value),
        .m_last    (m_tlast)
    );

    // pad the value with zeros up to a whole byte
    assign m_tdata = {{(hbe_pkg::M_TDATA_W - hbe_pkg::VALUE_W){1'b0}}, m_value};

endmodule

FILE: rtl/hbe_checker.sv
`include "assert_macros.svh"

module hbe_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [hbe_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);

    // a stalled beat stays up with its payload
    `HBE_ASSERT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // reset empties the output register
    `HBE_ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_tvalid)

    // the pad bits above the cipher value stay zero
    `HBE_ASSERT(a_pad_zero, aclk, aresetn, m_tvalid |-> m_tdata[hbe_pkg::M_TDATA_W-1:hbe_pkg::VALUE_W] == '0)

    // a fresh result is only loaded while the input is held off
    `HBE_ASSERT(a_load_busy, aclk, aresetn, $rose(m_tvalid) |-> $past(!s_tready))

endmodule

bind hill_block_encrypt hbe_checker u_hbe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: dv/hbe_cipher_check.sv
`timescale 1ns / 100ps

module hbe_cipher_check
    import hbe_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tlast,
    input  logic                  end_check,
    output int                    pending,
    output int                    fail_count,
    output int                    beats_checked
);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } cipher_beat_t;

    cipher_beat_t cipher_q[$];

    // Shadow copy of the configuration and of the block being gathered
    logic [2:0]  order_code;
    logic [63:0] key_word [5];
    logic [7:0]  held_bytes [MAX_ORDER_DEF];
    int unsigned held_count;
    bit          end_done;

    function automatic int unsigned order_of(input logic [2:0] code);
        if (code == 3'd0) return 1;
        if (int'(code) > MAX_ORDER_DEF) return MAX_ORDER_DEF;
        return int'(code);
    endfunction

    function automatic logic [7:0] key_byte(input int unsigned idx);
        if (idx >= KEY_BYTES) return 8'h00;
        return key_word[idx >> 3][(idx % 8) * 8 +: 8];
    endfunction

    task automatic report(input string msg);
        fail_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Gather one byte; a full block or the end of message yields n column sums.
    task automatic encrypt_byte(input logic [7:0] b, input logic eom);
        int unsigned  n;
        int unsigned  acc;
        cipher_beat_t beat;
        n = order_of(order_code);
        if (held_count >= n) held_count = 0;
        held_bytes[held_count] = b;
        held_count++;
        if (held_count < n && !eom) return;
        for (int unsigned j = 0; j < n; j++) begin
            acc = 0;
            for (int unsigned i = 0; i < n; i++) begin
                if (i < held_count)
                    acc += 32'(held_bytes[i]) * 32'(key_byte(i * n + j));
            end
            beat.value = acc[VALUE_W-1:0];
            beat.last  = (j + 1 == n);
            cipher_q.push_back(beat);
        end
        held_count = 0;
    endtask

    task automatic check_beat(input logic [M_TDATA_W-1:0] data, input logic last);
        cipher_beat_t want;
        if (cipher_q.size() == 0) begin
            report($sformatf("unexpected beat value=%0d last=%0b",
                             data[VALUE_W-1:0], last));
            return;
        end
        want = cipher_q.pop_front();
        beats_checked++;
        if (data[VALUE_W-1:0] !== want.value)
            report($sformatf("cipher_value got %0d want %0d", data[VALUE_W-1:0], want.value));
        if (last !== want.last)
            report($sformatf("block_last got %0b want %0b", last, want.last));
        if (data[M_TDATA_W-1:VALUE_W] !== '0)
            report($sformatf("tdata pad bits not zero: %h", data[M_TDATA_W-1:VALUE_W]));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            order_code = 3'd1;
            for (int w = 0; w < 5; w++) key_word[w] = '0;
            held_count = 0;
            cipher_q.delete();
            end_done      = 1'b0;
            fail_count    = 0;
            beats_checked = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_BLOCK_SIZE: order_code  = cfg_wdata[2:0];
                    REG_KEY_WORD_0: key_word[0] = cfg_wdata;
                    REG_KEY_WORD_1: key_word[1] = cfg_wdata;
                    REG_KEY_WORD_2: key_word[2] = cfg_wdata;
                    REG_KEY_WORD_3: key_word[3] = cfg_wdata;
                    REG_KEY_WORD_4: key_word[4] = {32'h0, cfg_wdata[31:0]};
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) check_beat(m_tdata, m_tlast);
            if (s_tvalid && s_tready) encrypt_byte(s_tdata, s_tlast);
            if (end_check && !end_done) begin
                end_done = 1'b1;
                while (cipher_q.size() != 0) begin
                    report($sformatf("cipher value %0d never arrived",
                                     cipher_q[0].value));
                    void'(cipher_q.pop_front());
                end
            end
        end
        pending <= cipher_q.size();
    end

endmodule

FILE: dv/tb_hill_block_encrypt.sv
`timescale 1ns / 100ps

module tb_hill_block_encrypt;
    import hbe_pkg::*;

    // Wait out the longest compute burst for a closing byte, with margin.
    localparam int DRAIN_CYCLES = MAX_ORDER_DEF * (MAX_ORDER_DEF + 1) + 8;
    // Cycles with no beat and no register write before the run is abandoned.
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_BYTES = 430;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  end_check = 1'b0;

    int pending;
    int fail_count;
    int beats_checked;

    int       sent_bytes  = 0;
    int       phase_count = 0;
    bit [7:0] codes_seen  = '0;
    bit       no_idle     = 1'b0;   // both sides run back to back when set
    int       stall_left  = 0;
    int       next_stall;
    int       quiet_cycles = 0;

    always #5 aclk = ~aclk;

    hill_block_encrypt dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] message_byte
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [18:0] cipher_value, upper bits zero
        .m_tlast   (m_tlast)
    );

    hbe_cipher_check u_cipher_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .end_check     (end_check),
        .pending       (pending),
        .fail_count    (fail_count),
        .beats_checked (beats_checked)
    );

    // Receiver: after each accepted beat draw a random stall and hold
    // tready low for its length. One assignment per edge keeps tready
    // from dropping and rising in the same step.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            next_stall = no_idle ? 0 : $urandom_range(0, 9);
            stall_left <= next_stall;
            m_tready   <= (next_stall == 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= (stall_left == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: any beat or register write restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one byte after a random gap and hold it until the block takes it.
    // Leave tvalid high on return; the next call or wait_idle decides whether
    // it drops, so it is never lowered and raised in one step.
    task automatic send_byte(input logic [7:0] b, input logic eom);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eom;
        do @(posedge aclk); while (!s_tready);
        sent_bytes++;
    endtask

    // Stop sending, wait for every predicted value, then let any byte that
    // closed no block finish inside the block before touching registers.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Drive one register write; the caller drops cfg_we after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    initial begin
        int          target;
        int          count;
        int          len;
        int          order;
        int          key_mode;
        bit          open_end;
        bit          last_msg;
        bit          terminate;
        logic [2:0]  code;
        logic [63:0] val;
        logic [7:0]  b;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- Directed part ----
        // Order 6 with every key byte at 0xFF and message bytes at 0xFF gives
        // the largest column sum. Upper bits of key_word_4 must be ignored.
        write_reg(REG_BLOCK_SIZE, 64'd6);
        write_reg(REG_KEY_WORD_0, '1);
        write_reg(REG_KEY_WORD_1, '1);
        write_reg(REG_KEY_WORD_2, '1);
        write_reg(REG_KEY_WORD_3, '1);
        write_reg(REG_KEY_WORD_4, '1);
        cfg_we <= 1'b0;
        codes_seen[6] = 1'b1;
        repeat (6) send_byte(8'hFF, 1'b0);
        // End of message on the first byte: pad the other five with zeros.
        send_byte(8'h80, 1'b1);

        // Size code 0 behaves as order 1; the set upper data bits are dropped.
        wait_idle();
        write_reg(REG_BLOCK_SIZE, 64'hFFFF_FFFF_FFFF_FFF8);
        write_reg(REG_KEY_WORD_0, {$urandom, $urandom});
        cfg_we <= 1'b0;
        codes_seen[0] = 1'b1;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Size code 7 clamps to order 6; close a partial block of three.
        wait_idle();
        write_reg(REG_BLOCK_SIZE, 64'd7);
        write_reg(REG_KEY_WORD_0, {$urandom, $urandom});
        write_reg(REG_KEY_WORD_1, {$urandom, $urandom});
        write_reg(REG_KEY_WORD_2, {$urandom, $urandom});
        cfg_we <= 1'b0;
        codes_seen[7] = 1'b1;
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b1);

        // Leave four bytes held at order 5, then lower the order to 2: the
        // held bytes are dropped and the next byte opens a fresh block.
        wait_idle();
        write_reg(REG_BLOCK_SIZE, 64'd5);
        cfg_we <= 1'b0;
        codes_seen[5] = 1'b1;
        repeat (4) send_byte(8'($urandom_range(0, 255)), 1'b0);
        wait_idle();
        write_reg(REG_BLOCK_SIZE, 64'd2);
        cfg_we <= 1'b0;
        codes_seen[2] = 1'b1;
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);

        // All-zero key at order 3, padded block.
        wait_idle();
        write_reg(REG_BLOCK_SIZE, 64'd3);
        for (int w = 0; w < 5; w++) write_reg(REG_KEY_WORD_0 + CFG_IDX_W'(w), '0);
        cfg_we <= 1'b0;
        codes_seen[3] = 1'b1;
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);

        // End of message landing exactly on a full block, at orders 1 and 2.
        wait_idle();
        write_reg(REG_BLOCK_SIZE, 64'd1);
        write_reg(REG_KEY_WORD_0, {$urandom, $urandom});
        cfg_we <= 1'b0;
        codes_seen[1] = 1'b1;
        send_byte(8'hAA, 1'b1);
        wait_idle();
        write_reg(REG_BLOCK_SIZE, 64'd2);
        cfg_we <= 1'b0;
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b1);

        // ---- Random part ----
        // Each phase picks a size code and a key style, then sends messages
        // of random length that mostly end with tlast. A few messages run on
        // without it, and some phases stop mid-block so the next setting
        // meets held bytes.
        target = sent_bytes + RANDOM_BYTES;
        while (sent_bytes < target) begin
            wait_idle();
            code     = (phase_count < 8) ? 3'(phase_count) : 3'($urandom_range(0, 7));
            key_mode = $urandom_range(0, 3);
            no_idle  = ($urandom_range(0, 3) == 0);
            val      = {$urandom, $urandom};
            val[2:0] = code;
            write_reg(REG_BLOCK_SIZE, val);
            for (int w = 0; w < 5; w++) begin
                if (phase_count == 0 || $urandom_range(0, 1) == 1) begin
                    case (key_mode)
                        0:       val = {$urandom, $urandom};
                        1:       val = '1;
                        2:       val = '0;
                        default: val = {$urandom, $urandom} & {$urandom, $urandom} &
                                       {$urandom, $urandom};
                    endcase
                    write_reg(REG_KEY_WORD_0 + CFG_IDX_W'(w), val);
                end
            end
            cfg_we <= 1'b0;
            codes_seen[code] = 1'b1;
            phase_count++;

            order    = (code == 3'd0) ? 1 : ((int'(code) > MAX_ORDER_DEF) ?
                                             MAX_ORDER_DEF : int'(code));
            open_end = ($urandom_range(0, 5) == 0);
            len      = $urandom_range(20, 50);
            count    = 0;
            while (count < len) begin
                int mlen;
                mlen      = $urandom_range(1, 3 * order);
                last_msg  = (count + mlen >= len);
                terminate = !(last_msg && open_end) && ($urandom_range(0, 7) != 0);
                for (int k = 0; k < mlen; k++) begin
                    case ($urandom_range(0, 7))
                        0:       b = 8'h00;
                        1:       b = 8'hFF;
                        default: b = 8'($urandom);
                    endcase
                    send_byte(b, terminate && (k == mlen - 1));
                end
                count += mlen;
            end
        end

        // ---- Wrap up ----
        no_idle = 1'b0;
        wait_idle();
        end_check <= 1'b1;
        repeat (2) @(posedge aclk);
        $display("Sent %0d plaintext bytes across %0d random settings; size codes used %b",
                 sent_bytes, phase_count, codes_seen);
        $display("Compared %0d cipher values, %0d mismatches", beats_checked, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
